@@ rtl/pcr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_pkg - shared definitions for the phase/coherence colour map
// widths of the fixed ports, parameter defaults, sector codes and the
// control word that travels down the pipeline with each pixel
// ----------------------------------------------------------------------------
package pcr_pkg;

	// parameter defaults
	localparam int PHASE_BITS_DEF      = 16;
	localparam int LEVEL_FRAC_BITS_DEF = 16;

	// fixed port widths
	localparam int PHASE_IN_W = 16;
	localparam int LEVEL_IN_W = 18;
	localparam int CHAN_W     = 17;

	// configuration port
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	// register index, as held in the word-address bit of paddr
	localparam logic REG_COHERENCE_ENABLE = 1'b0;

	// hue sectors of the six-sector rule
	typedef enum logic [2:0] {
		SECT_RED_YELLOW    = 3'd0,
		SECT_YELLOW_GREEN  = 3'd1,
		SECT_GREEN_CYAN    = 3'd2,
		SECT_CYAN_BLUE     = 3'd3,
		SECT_BLUE_MAGENTA  = 3'd4,
		SECT_MAGENTA_RED   = 3'd5
	} sector_t;

	// per-pixel control word carried alongside the datapath
	typedef struct packed {
		logic    valid;
		logic    last;
		sector_t sector;
	} ctl_t;

endpackage

@@ rtl/pcr_hue_clamp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_hue_clamp - stage 1: hue, sector split and level clamp
// turns the binary phase into a hue, splits six times the hue into sector
// and sector fraction, and clamps the coherence level into saturation
// ----------------------------------------------------------------------------
module pcr_hue_clamp #(
	parameter int PHASE_BITS      = pcr_pkg::PHASE_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = pcr_pkg::LEVEL_FRAC_BITS_DEF
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      in_valid,
	input  logic signed [pcr_pkg::PHASE_IN_W-1:0]     phase_angle,
	input  logic signed [pcr_pkg::LEVEL_IN_W-1:0]     coherence_level,
	input  logic                                      last,
	input  logic                                      coherence_enable,
	output pcr_pkg::ctl_t                             ctl_s1,
	output logic        [PHASE_BITS-1:0]              rem_s1,
	output logic        [LEVEL_FRAC_BITS:0]           sat_s1
);

	localparam int PB = PHASE_BITS;
	localparam int LF = LEVEL_FRAC_BITS;
	localparam int SW = LF + 1;
	localparam int HW = PB + 3;
	localparam int LW = LF + pcr_pkg::LEVEL_IN_W - 1;
	localparam logic [SW-1:0] ONE     = SW'(1) << LF;
	localparam logic [LW-1:0] ONE_EXT = LW'(1) << LF;

	logic [PB+pcr_pkg::PHASE_IN_W-1:0] ph_ext;
	logic [PB-1:0]                     ph;
	logic [PB-1:0]                     hue;
	logic [HW-1:0]                     hh;
	logic [LW-1:0]                     lvl_ext;
	logic [SW-1:0]                     sat;

	// sign-extend then keep the phase width
	assign ph_ext = {{PB{phase_angle[pcr_pkg::PHASE_IN_W-1]}}, phase_angle};
	assign ph     = ph_ext[PB-1:0];
	// adding half a turn flips the top bit
	assign hue    = {~ph[PB-1], ph[PB-2:0]};
	// six times hue as two shifted adds
	assign hh     = (HW'(hue) << 2) + (HW'(hue) << 1);

	assign lvl_ext = LW'(coherence_level[pcr_pkg::LEVEL_IN_W-2:0]);

	always_comb begin
		if (!coherence_enable) begin
			sat = ONE;
		end else if (coherence_level[pcr_pkg::LEVEL_IN_W-1]) begin
			sat = '0;
		end else if (lvl_ext > ONE_EXT) begin
			sat = ONE;
		end else begin
			sat = lvl_ext[SW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid  <= in_valid;
			ctl_s1.last   <= last;
			ctl_s1.sector <= pcr_pkg::sector_t'(hh[HW-1:PB]);
		end
	end

	always_ff @(posedge clk) begin
		rem_s1 <= hh[PB-1:0];
		sat_s1 <= sat;
	end

endmodule

@@ rtl/pcr_frac_mult.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_frac_mult - stage 2: saturation products
// saturation times the sector fraction and its complement, and the
// value-times-one-minus-saturation term
// ----------------------------------------------------------------------------
module pcr_frac_mult #(
	parameter int PHASE_BITS      = pcr_pkg::PHASE_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = pcr_pkg::LEVEL_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pcr_pkg::ctl_t              ctl_s1,
	input  logic [PHASE_BITS-1:0]      rem_s1,
	input  logic [LEVEL_FRAC_BITS:0]   sat_s1,
	output pcr_pkg::ctl_t              ctl_s2,
	output logic [LEVEL_FRAC_BITS:0]   sat_s2,
	output logic [LEVEL_FRAC_BITS:0]   sf_s2,
	output logic [LEVEL_FRAC_BITS:0]   sfc_s2,
	output logic [LEVEL_FRAC_BITS:0]   p_s2
);

	localparam int PB  = PHASE_BITS;
	localparam int LF  = LEVEL_FRAC_BITS;
	localparam int SW  = LF + 1;
	localparam int FW  = SW + PB;
	localparam int CW  = SW + PB + 1;
	localparam int PW  = 2 * SW;
	localparam logic [SW-1:0] ONE   = SW'(1) << LF;
	localparam logic [PB:0]   TURN  = (PB + 1)'(1) << PB;

	logic [PB:0]   comp;
	logic [SW-1:0] oms;
	logic [FW-1:0] prod_sf;
	logic [CW-1:0] prod_sfc;
	logic [PW-1:0] prod_p;

	assign comp     = TURN - (PB + 1)'(rem_s1);
	assign oms      = ONE - sat_s1;
	assign prod_sf  = FW'(sat_s1) * FW'(rem_s1);
	assign prod_sfc = CW'(sat_s1) * CW'(comp);
	assign prod_p   = PW'(sat_s1) * PW'(oms);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	// products never exceed saturation, so the upper bits drop cleanly
	always_ff @(posedge clk) begin
		sat_s2 <= sat_s1;
		sf_s2  <= prod_sf[LF+PB:PB];
		sfc_s2 <= prod_sfc[LF+PB:PB];
		p_s2   <= prod_p[2*LF:LF];
	end

endmodule

@@ rtl/pcr_level_mult.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_level_mult - stage 3: value products
// forms the falling and rising ramps q and t from the value
// ----------------------------------------------------------------------------
module pcr_level_mult #(
	parameter int LEVEL_FRAC_BITS = pcr_pkg::LEVEL_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  pcr_pkg::ctl_t              ctl_s2,
	input  logic [LEVEL_FRAC_BITS:0]   sat_s2,
	input  logic [LEVEL_FRAC_BITS:0]   sf_s2,
	input  logic [LEVEL_FRAC_BITS:0]   sfc_s2,
	input  logic [LEVEL_FRAC_BITS:0]   p_s2,
	output pcr_pkg::ctl_t              ctl_s3,
	output logic [LEVEL_FRAC_BITS:0]   v_s3,
	output logic [LEVEL_FRAC_BITS:0]   p_s3,
	output logic [LEVEL_FRAC_BITS:0]   q_s3,
	output logic [LEVEL_FRAC_BITS:0]   t_s3
);

	localparam int LF = LEVEL_FRAC_BITS;
	localparam int SW = LF + 1;
	localparam int PW = 2 * SW;
	localparam logic [SW-1:0] ONE = SW'(1) << LF;

	logic [SW-1:0] omsf;
	logic [SW-1:0] omsfc;
	logic [PW-1:0] prod_q;
	logic [PW-1:0] prod_t;

	assign omsf   = ONE - sf_s2;
	assign omsfc  = ONE - sfc_s2;
	assign prod_q = PW'(sat_s2) * PW'(omsf);
	assign prod_t = PW'(sat_s2) * PW'(omsfc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3 <= '0;
		end else begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		v_s3 <= sat_s2;
		p_s3 <= p_s2;
		q_s3 <= prod_q[2*LF:LF];
		t_s3 <= prod_t[2*LF:LF];
	end

endmodule

@@ rtl/pcr_sector_sel.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcr_sector_sel - stage 4: sector select and output register
// routes v, p, q and t onto red, green and blue by hue sector
// ----------------------------------------------------------------------------
module pcr_sector_sel #(
	parameter int LEVEL_FRAC_BITS = pcr_pkg::LEVEL_FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pcr_pkg::ctl_t                     ctl_s3,
	input  logic [LEVEL_FRAC_BITS:0]          v_s3,
	input  logic [LEVEL_FRAC_BITS:0]          p_s3,
	input  logic [LEVEL_FRAC_BITS:0]          q_s3,
	input  logic [LEVEL_FRAC_BITS:0]          t_s3,
	output logic                              done_s4,
	output logic [pcr_pkg::CHAN_W-1:0]        red_s4,
	output logic [pcr_pkg::CHAN_W-1:0]        green_s4,
	output logic [pcr_pkg::CHAN_W-1:0]        blue_s4,
	output logic                              last_s4
);

	localparam int SW = LEVEL_FRAC_BITS + 1;
	localparam int XW = SW + pcr_pkg::CHAN_W;

	logic [SW-1:0] r;
	logic [SW-1:0] g;
	logic [SW-1:0] b;
	logic [XW-1:0] r_ext;
	logic [XW-1:0] g_ext;
	logic [XW-1:0] b_ext;

	always_comb begin
		case (ctl_s3.sector)
			pcr_pkg::SECT_RED_YELLOW: begin
				r = v_s3; g = t_s3; b = p_s3;
			end
			pcr_pkg::SECT_YELLOW_GREEN: begin
				r = q_s3; g = v_s3; b = p_s3;
			end
			pcr_pkg::SECT_GREEN_CYAN: begin
				r = p_s3; g = v_s3; b = t_s3;
			end
			pcr_pkg::SECT_CYAN_BLUE: begin
				r = p_s3; g = q_s3; b = v_s3;
			end
			pcr_pkg::SECT_BLUE_MAGENTA: begin
				r = t_s3; g = p_s3; b = v_s3;
			end
			default: begin
				r = v_s3; g = p_s3; b = q_s3;
			end
		endcase
	end

	// zero-extend then keep the channel width, so wide fractions wrap
	assign r_ext = XW'(r);
	assign g_ext = XW'(g);
	assign b_ext = XW'(b);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s4 <= 1'b0;
		end else begin
			done_s4 <= ctl_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		red_s4   <= r_ext[pcr_pkg::CHAN_W-1:0];
		green_s4 <= g_ext[pcr_pkg::CHAN_W-1:0];
		blue_s4  <= b_ext[pcr_pkg::CHAN_W-1:0];
		last_s4  <= ctl_s3.last;
	end

endmodule

@@ rtl/phase_coherence_to_rgb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// phase_coherence_to_rgb - phase and coherence to rgb colour map
// per pixel: phase gives hue, clamped coherence gives saturation and value,
// then a six-sector hsv to rgb conversion in fixed point
// ----------------------------------------------------------------------------
// One pixel request is taken on every clock at which start is high; busy is
// always low, so requests may come back to back without a gap. Each request
// gives exactly one result: red, green, blue and last_out are valid for the
// single cycle in which done is high. There is no way to hold results off, so
// the receiver must capture every done cycle. Each result passes through
// four register stages: hue split and level clamp, saturation products, value
// products, and sector select with the output register. coherence_enable is
// written over the register port and should only change while no pixel is in
// flight.
// ----------------------------------------------------------------------------
module phase_coherence_to_rgb #(
	parameter int PHASE_BITS      = pcr_pkg::PHASE_BITS_DEF,
	parameter int LEVEL_FRAC_BITS = pcr_pkg::LEVEL_FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,

	// register port
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic        [pcr_pkg::APB_ADDR_W-1:0] paddr,
	input  logic        [pcr_pkg::APB_DATA_W-1:0] pwdata,
	output logic        [pcr_pkg::APB_DATA_W-1:0] prdata,
	output logic                                  pready,

	// pixel request
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [pcr_pkg::PHASE_IN_W-1:0] phase_angle,
	input  logic signed [pcr_pkg::LEVEL_IN_W-1:0] coherence_level,
	input  logic                                  last,

	// pixel result
	output logic                                  done,
	output logic        [pcr_pkg::CHAN_W-1:0]     red,
	output logic        [pcr_pkg::CHAN_W-1:0]     green,
	output logic        [pcr_pkg::CHAN_W-1:0]     blue,
	output logic                                  last_out
);

	localparam int LF = LEVEL_FRAC_BITS;

	// register word address sits above the byte lanes
	localparam int REG_SEL_BIT = 2;

	logic                 coh_en_q;
	logic                 reg_wr;
	logic                 req_valid;

	pcr_pkg::ctl_t        ctl_s1;
	pcr_pkg::ctl_t        ctl_s2;
	pcr_pkg::ctl_t        ctl_s3;
	logic [PHASE_BITS-1:0] rem_s1;
	logic [LF:0]          sat_s1;
	logic [LF:0]          sat_s2;
	logic [LF:0]          sf_s2;
	logic [LF:0]          sfc_s2;
	logic [LF:0]          p_s2;
	logic [LF:0]          v_s3;
	logic [LF:0]          p_s3;
	logic [LF:0]          q_s3;
	logic [LF:0]          t_s3;

	// ------------------------------------------------------------------
	// register port: zero-wait writes and reads
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign reg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coh_en_q <= 1'b0;
		end else if (reg_wr && (paddr[REG_SEL_BIT] == pcr_pkg::REG_COHERENCE_ENABLE)) begin
			coh_en_q <= pwdata[0];
		end
	end

	// unmapped addresses read as zero
	always_comb begin
		if (paddr[REG_SEL_BIT] == pcr_pkg::REG_COHERENCE_ENABLE) begin
			prdata = pcr_pkg::APB_DATA_W'(coh_en_q);
		end else begin
			prdata = '0;
		end
	end

	// ------------------------------------------------------------------
	// request side: fully pipelined, never stalls
	// ------------------------------------------------------------------
	assign busy      = 1'b0;
	assign req_valid = start & ~busy;

	// stage 1: hue, sector and clamped saturation
	pcr_hue_clamp #(
		.PHASE_BITS      (PHASE_BITS),
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
	) u_hue_clamp (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (req_valid),
		.phase_angle      (phase_angle),
		.coherence_level  (coherence_level),
		.last             (last),
		.coherence_enable (coh_en_q),
		.ctl_s1           (ctl_s1),
		.rem_s1           (rem_s1),
		.sat_s1           (sat_s1)
	);

	// stage 2: saturation times fraction, complement, and the p term
	pcr_frac_mult #(
		.PHASE_BITS      (PHASE_BITS),
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
	) u_frac_mult (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.rem_s1 (rem_s1),
		.sat_s1 (sat_s1),
		.ctl_s2 (ctl_s2),
		.sat_s2 (sat_s2),
		.sf_s2  (sf_s2),
		.sfc_s2 (sfc_s2),
		.p_s2   (p_s2)
	);

	// stage 3: value times the ramp complements
	pcr_level_mult #(
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
	) u_level_mult (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s2 (ctl_s2),
		.sat_s2 (sat_s2),
		.sf_s2  (sf_s2),
		.sfc_s2 (sfc_s2),
		.p_s2   (p_s2),
		.ctl_s3 (ctl_s3),
		.v_s3   (v_s3),
		.p_s3   (p_s3),
		.q_s3   (q_s3),
		.t_s3   (t_s3)
	);

	// stage 4: sector routing into the output register
	pcr_sector_sel #(
		.LEVEL_FRAC_BITS (LEVEL_FRAC_BITS)
	) u_sector_sel (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s3   (ctl_s3),
		.v_s3     (v_s3),
		.p_s3     (p_s3),
		.q_s3     (q_s3),
		.t_s3     (t_s3),
		.done_s4  (done),
		.red_s4   (red),
		.green_s4 (green),
		.blue_s4  (blue),
		.last_s4  (last_out)
	);

endmodule
